/* sv/sfa_pkg.sv */
`default_nettype none

package sfa_pkg;

  localparam int unsigned MEM_UNITS = 2048;
  localparam logic [11:0] RESET_MEM = 12'd2000;

  localparam int unsigned AW   = 11;  // unit address
  localparam int unsigned LW   = 12;  // hole / segment length
  localparam int unsigned TOTW = 16;  // staged total

  localparam logic CMD_STAGE = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic REG_FIT_POLICY  = 1'b0;
  localparam logic REG_MEMORY_SIZE = 1'b1;

  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef enum logic [2:0] {
    ST_PLACED   = 3'd0,
    ST_NOFIT    = 3'd1,
    ST_EXCEEDS  = 3'd2,
    ST_FREED    = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    OP_HOLD    = 3'd0,
    OP_ROT     = 3'd1,
    OP_MOD     = 3'd2,
    OP_INS     = 3'd3,
    OP_DEL     = 3'd4,
    OP_COMMIT  = 3'd5,
    OP_RESTORE = 3'd6,
    OP_INIT    = 3'd7
  } cell_op_e;

  typedef struct packed {
    logic [AW-1:0] start;
    logic [LW-1:0] len;
  } hole_t;

  typedef struct packed {
    cell_op_e op;
    hole_t    entry;
  } hole_cmd_t;

endpackage

`default_nettype wire

/* sv/sfa_req_if.sv */
`default_nettype none

interface sfa_req_if;
  import sfa_pkg::*;

  logic          valid;
  logic          ready;
  logic          command;
  logic [LW-1:0] segment_size;
  logic          last_segment;
  logic [AW-1:0] region_start;
  logic [LW-1:0] region_size;

  modport source (output valid, command, segment_size, last_segment, region_start,
                  region_size, input ready);
  modport sink (input valid, command, segment_size, last_segment, region_start,
                region_size, output ready);
endinterface

`default_nettype wire

/* sv/sfa_rsp_if.sv */
`default_nettype none

interface sfa_rsp_if;
  import sfa_pkg::*;

  logic          valid;
  logic          ready;
  logic [2:0]    status;
  logic [3:0]    segment_index;
  logic [AW-1:0] segment_start;
  logic          last;

  modport source (output valid, status, segment_index, segment_start, last, input ready);
  modport sink (input valid, status, segment_index, segment_start, last, output ready);
endinterface

`default_nettype wire

/* sv/sfa_cell.sv */
`default_nettype none

module sfa_cell #(
  parameter int unsigned IW  = 6,
  parameter int unsigned IDX = 0
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire sfa_pkg::hole_cmd_t cmd_i,
  input  wire logic [IW-1:0]     sel_i,
  input  wire sfa_pkg::hole_t    left_i,
  input  wire sfa_pkg::hole_t    right_i,
  output sfa_pkg::hole_t         work_o
);
  import sfa_pkg::*;

  hole_t work_q;
  hole_t shadow_q;
  logic  hit;
  logic  above;

  assign hit    = (sel_i == IW'(IDX));
  assign above  = (sel_i < IW'(IDX));
  assign work_o = work_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      work_q   <= '{start: '0, len: RESET_MEM};
      shadow_q <= '{start: '0, len: RESET_MEM};
    end else begin
      case (cmd_i.op)
        OP_ROT: begin
          work_q <= right_i;
        end
        OP_MOD: begin
          if (hit) work_q <= cmd_i.entry;
        end
        OP_INS: begin
          if (hit) work_q <= cmd_i.entry;
          else if (above) work_q <= left_i;
        end
        OP_DEL: begin
          if (hit || above) work_q <= right_i;
        end
        OP_COMMIT: begin
          shadow_q <= work_q;
        end
        OP_RESTORE: begin
          work_q <= shadow_q;
        end
        OP_INIT: begin
          work_q   <= cmd_i.entry;
          shadow_q <= cmd_i.entry;
        end
        default: begin
        end
      endcase
    end
  end

endmodule

`default_nettype wire

/* sv/sfa_chain.sv */
`default_nettype none

module sfa_chain #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IW    = 6
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire sfa_pkg::hole_cmd_t cmd_i,
  input  wire logic [IW-1:0]      sel_i,
  output sfa_pkg::hole_t          head_o
);
  import sfa_pkg::*;

  hole_t work [DEPTH];

  assign head_o = work[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    hole_t left;
    hole_t right;
    if (i == 0) begin : g_first
      assign left = cmd_i.entry;
    end else begin : g_mid_l
      assign left = work[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = work[0];  // ring wrap
    end else begin : g_mid_r
      assign right = work[i+1];
    end
    sfa_cell #(.IW(IW), .IDX(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cmd_i),
      .sel_i   (sel_i),
      .left_i  (left),
      .right_i (right),
      .work_o  (work[i])
    );
  end

endmodule

`default_nettype wire

/* sv/segment_fit_allocator_top.sv */
`default_nettype none
// Channel   Dir  Payload                                                   Accepted when
// req       in   command, segment_size, last_segment, region_start, size   valid & ready
// rsp       out  status, segment_index, segment_start, last                valid & ready
// cfg       in   cfg_idx_i, cfg_data_i (0 fit_policy, 1 memory_size)       cfg_we_i
//
// Each placed segment takes one full turn of the hole ring plus one edit step;
// a placement adds one commit step. A free takes a ring turn, an edit and a
// commit, plus one delete step for each absorbed hole beyond the first.
// Results leave one a cycle while rsp.ready holds.
// Reset brings up one hole of 2000 units, no clearing pass. req is taken only in idle;
// a waiting result in the output register does not block the next request.
module segment_fit_allocator_top #(
  parameter int unsigned MAX_HOLES    = 64,
  parameter int unsigned MAX_SEGMENTS = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic        cfg_idx_i,
  input  wire logic [11:0] cfg_data_i,
  sfa_req_if.sink          req,
  sfa_rsp_if.source        rsp
);
  import sfa_pkg::*;

  localparam int unsigned IW  = (MAX_HOLES > 1) ? $clog2(MAX_HOLES) : 1;
  localparam int unsigned CW  = $clog2(MAX_HOLES + 1);
  localparam int unsigned SIW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int unsigned SCW = $clog2(MAX_SEGMENTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_PSCAN  = 3'd1;  // one ring turn, pick a hole for one segment
  localparam logic [2:0] S_PEDIT  = 3'd2;  // shrink or drop the picked hole, or restore the ring on no fit
  localparam logic [2:0] S_FSCAN  = 3'd3;  // one ring turn, find merge range
  localparam logic [2:0] S_FEDIT  = 3'd4;  // insert or rewrite merged hole
  localparam logic [2:0] S_FDEL   = 3'd5;  // drop absorbed holes one per cycle
  localparam logic [2:0] S_COMMIT = 3'd6;  // working ring -> shadow copy
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]      state_q;
  logic [IW-1:0]   t_q;
  logic [CW-1:0]   nw_q, nc_q;         // working / committed hole count
  logic [1:0]      fit_q;
  logic [11:0]     msize_q;
  logic [SCW-1:0]  stg_cnt_q;
  logic [TOTW-1:0] tot_q;
  logic [SIW-1:0]  seg_q;
  logic            found_q;
  logic [IW-1:0]   pk_idx_q;
  hole_t           pk_q;
  logic [AW-1:0]   rs_q, ms_q;
  logic [LW-1:0]   me_q;
  logic            pre_q, done_q;
  logic [CW-1:0]   p_q, a_q, del_q;
  logic            single_q;
  status_e         pend_q;
  logic            out_valid_q;
  status_e         out_status_q;
  logic [3:0]      out_idx_q;
  logic [AW-1:0]   out_start_q;
  logic            out_last_q;

  logic [LW-1:0]   stg_size_q [MAX_SEGMENTS];
  logic [AW-1:0]   res_start_q [MAX_SEGMENTS];

  hole_t           hd;
  hole_cmd_t       cmd;
  logic [IW-1:0]   sel;
  logic            req_fire;
  logic            load;
  logic            head_valid;
  logic            cand;
  logic            pl_ok;
  logic [LW-1:0]   sz;
  logic [LW-1:0]   newlen;
  logic [LW-1:0]   hend;
  hole_t           merged;
  logic [TOTW-1:0] tot_new;
  logic [12:0]     rend;
  logic [11:0]     clamp;

  sfa_chain #(.DEPTH(MAX_HOLES), .IW(IW)) u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sel_i  (sel),
    .head_o (hd)
  );

  assign req.ready         = (state_q == S_IDLE);
  assign req_fire          = req.valid && req.ready;
  assign rsp.valid         = out_valid_q;
  assign rsp.status        = out_status_q;
  assign rsp.segment_index = out_idx_q;
  assign rsp.segment_start = out_start_q;
  assign rsp.last          = out_last_q;
  assign load              = !out_valid_q || rsp.ready;

  assign sz         = stg_size_q[0];
  assign head_valid = (CW'(t_q) < nw_q);
  assign pl_ok      = found_q && (pk_q.len >= sz);
  assign newlen     = pk_q.len - sz;
  assign hend       = LW'(hd.start) + hd.len;
  assign merged     = '{start: ms_q, len: me_q - LW'(ms_q)};
  assign tot_new    = tot_q + TOTW'(req.segment_size);
  assign rend       = 13'(req.region_start) + 13'(req.region_size);

  always_comb begin
    if (cfg_data_i == 12'd0) clamp = 12'd1;
    else if (cfg_data_i > 12'(MEM_UNITS)) clamp = 12'(MEM_UNITS);
    else clamp = cfg_data_i;
  end

  // fit test of the hole at the ring head
  always_comb begin
    case (fit_q)
      POL_BEST:  cand = (hd.len >= sz) && (!found_q || hd.len < pk_q.len);
      POL_WORST: cand = !found_q || (hd.len > pk_q.len);
      default:   cand = (hd.len >= sz) && !found_q;
    endcase
  end

  // ring command
  always_comb begin
    cmd.op    = OP_HOLD;
    cmd.entry = merged;
    sel       = '0;
    case (state_q)
      S_PSCAN, S_FSCAN: begin
        cmd.op = OP_ROT;
      end
      S_PEDIT: begin
        sel       = pk_idx_q;
        cmd.entry = '{start: pk_q.start + AW'(sz), len: newlen};
        if (!pl_ok) cmd.op = OP_RESTORE;
        else if (newlen == '0) cmd.op = OP_DEL;
        else cmd.op = OP_MOD;
      end
      S_FEDIT: begin
        sel = p_q[IW-1:0];
        if (a_q != '0) cmd.op = OP_MOD;
        else if (nw_q != CW'(MAX_HOLES)) cmd.op = OP_INS;
      end
      S_FDEL: begin
        sel    = IW'(p_q + CW'(1));
        cmd.op = OP_DEL;
      end
      S_COMMIT: begin
        cmd.op = OP_COMMIT;
      end
      default: begin
      end
    endcase
    if (cfg_we_i && cfg_idx_i == REG_MEMORY_SIZE) begin
      cmd.op    = OP_INIT;
      cmd.entry = '{start: '0, len: clamp};
    end
  end

  // staged sizes and placed starts, read at the front only
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_fire && req.command == CMD_STAGE &&
        stg_cnt_q < SCW'(MAX_SEGMENTS)) begin
      stg_size_q[stg_cnt_q[SIW-1:0]] <= req.segment_size;
    end
    if (state_q == S_PEDIT && pl_ok) begin
      res_start_q[seg_q] <= pk_q.start;
      for (int i = 0; i < MAX_SEGMENTS - 1; i++) stg_size_q[i] <= stg_size_q[i+1];
    end
    if (state_q == S_EMIT && load && !single_q) begin
      for (int i = 0; i < MAX_SEGMENTS - 1; i++) res_start_q[i] <= res_start_q[i+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      t_q          <= '0;
      nw_q         <= CW'(1);
      nc_q         <= CW'(1);
      fit_q        <= POL_FIRST;
      msize_q      <= RESET_MEM;
      stg_cnt_q    <= '0;
      tot_q        <= '0;
      seg_q        <= '0;
      found_q      <= 1'b0;
      pk_idx_q     <= '0;
      pk_q         <= '0;
      rs_q         <= '0;
      ms_q         <= '0;
      me_q         <= '0;
      pre_q        <= 1'b0;
      done_q       <= 1'b0;
      p_q          <= '0;
      a_q          <= '0;
      del_q        <= '0;
      single_q     <= 1'b1;
      pend_q       <= ST_FREED;
      out_valid_q  <= 1'b0;
      out_status_q <= ST_PLACED;
      out_idx_q    <= '0;
      out_start_q  <= '0;
      out_last_q   <= 1'b0;
    end else begin
      if (rsp.ready) out_valid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (req_fire) begin
            if (req.command == CMD_FREE) begin
              if ({1'b0, req.region_start} >= msize_q || req.region_size == '0) begin
                single_q <= 1'b1;
                pend_q   <= ST_FREED;
                state_q  <= S_EMIT;
              end else begin
                rs_q    <= req.region_start;
                ms_q    <= req.region_start;
                me_q    <= (rend > 13'(msize_q)) ? msize_q : rend[11:0];
                pre_q   <= 1'b1;
                done_q  <= 1'b0;
                p_q     <= '0;
                a_q     <= '0;
                t_q     <= '0;
                state_q <= S_FSCAN;
              end
            end else if (stg_cnt_q >= SCW'(MAX_SEGMENTS)) begin
              stg_cnt_q <= '0;
              tot_q     <= '0;
              single_q  <= 1'b1;
              pend_q    <= ST_OVERFLOW;
              state_q   <= S_EMIT;
            end else begin
              stg_cnt_q <= stg_cnt_q + SCW'(1);
              tot_q     <= tot_new;
              if (req.last_segment) begin
                tot_q <= '0;
                if (tot_new > TOTW'(msize_q)) begin
                  stg_cnt_q <= '0;
                  single_q  <= 1'b1;
                  pend_q    <= ST_EXCEEDS;
                  state_q   <= S_EMIT;
                end else begin
                  seg_q   <= '0;
                  found_q <= 1'b0;
                  t_q     <= '0;
                  state_q <= S_PSCAN;
                end
              end
            end
          end
        end
        S_PSCAN: begin
          if (head_valid && cand) begin
            found_q  <= 1'b1;
            pk_idx_q <= t_q;
            pk_q     <= hd;
          end
          t_q <= t_q + IW'(1);
          if (t_q == IW'(MAX_HOLES - 1)) state_q <= S_PEDIT;
        end
        S_PEDIT: begin
          found_q <= 1'b0;
          t_q     <= '0;
          if (!pl_ok) begin
            nw_q      <= nc_q;
            stg_cnt_q <= '0;
            single_q  <= 1'b1;
            pend_q    <= ST_NOFIT;
            state_q   <= S_EMIT;
          end else begin
            if (newlen == '0) nw_q <= nw_q - CW'(1);
            if (SCW'(seg_q) + SCW'(1) == stg_cnt_q) begin
              single_q <= 1'b0;
              state_q  <= S_COMMIT;
            end else begin
              seg_q   <= seg_q + SIW'(1);
              state_q <= S_PSCAN;
            end
          end
        end
        S_FSCAN: begin
          if (head_valid && !done_q) begin
            if (pre_q && hend < LW'(rs_q)) begin
              p_q <= p_q + CW'(1);
            end else if (LW'(hd.start) <= me_q) begin
              pre_q <= 1'b0;
              a_q   <= a_q + CW'(1);
              if (hd.start < ms_q) ms_q <= hd.start;
              if (hend > me_q) me_q <= hend;
            end else begin
              pre_q  <= 1'b0;
              done_q <= 1'b1;
            end
          end
          t_q <= t_q + IW'(1);
          if (t_q == IW'(MAX_HOLES - 1)) state_q <= S_FEDIT;
        end
        S_FEDIT: begin
          single_q <= 1'b1;
          pend_q   <= ST_FREED;
          del_q    <= a_q - CW'(1);
          if (a_q == '0) begin
            if (nw_q == CW'(MAX_HOLES)) begin
              pend_q  <= ST_OVERFLOW;
              state_q <= S_EMIT;
            end else begin
              nw_q    <= nw_q + CW'(1);
              state_q <= S_COMMIT;
            end
          end else if (a_q == CW'(1)) begin
            state_q <= S_COMMIT;
          end else begin
            state_q <= S_FDEL;
          end
        end
        S_FDEL: begin
          nw_q  <= nw_q - CW'(1);
          del_q <= del_q - CW'(1);
          if (del_q == CW'(1)) state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          nc_q    <= nw_q;
          seg_q   <= '0;
          state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            out_valid_q <= 1'b1;
            if (single_q) begin
              out_status_q <= pend_q;
              out_idx_q    <= '0;
              out_start_q  <= '0;
              out_last_q   <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              out_status_q <= ST_PLACED;
              out_idx_q    <= 4'(seg_q);
              out_start_q  <= res_start_q[0];
              if (SCW'(seg_q) + SCW'(1) == stg_cnt_q) begin
                out_last_q <= 1'b1;
                stg_cnt_q  <= '0;
                state_q    <= S_IDLE;
              end else begin
                out_last_q <= 1'b0;
                seg_q      <= seg_q + SIW'(1);
              end
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase

      if (cfg_we_i) begin
        if (cfg_idx_i == REG_FIT_POLICY) begin
          fit_q <= cfg_data_i[1:0];
        end else begin
          msize_q   <= clamp;
          nw_q      <= CW'(1);
          nc_q      <= CW'(1);
          stg_cnt_q <= '0;
          tot_q     <= '0;
        end
      end
    end
  end

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (nw_q <= CW'(MAX_HOLES)) && (nc_q <= CW'(MAX_HOLES)))
    else $error("hole count beyond table depth");

  a_idle_aligned: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE) |-> (nw_q == nc_q))
    else $error("working ring not committed or restored at idle");

  a_stage_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stg_cnt_q <= SCW'(MAX_SEGMENTS))
    else $error("staging count overrun");

  a_out_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> ($past(state_q) == S_EMIT))
    else $error("result raised outside emit");

endmodule

`default_nettype wire
